// ===== src/mre_pkg.sv =====
// package for the mean reprojection error block
// shared types and constants; no dependencies
`default_nettype none
package mre_pkg;

    localparam int MaxPoints = 4096;
    localparam int CountW = 13;
    localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [31:0] NoneMean = -32'sd65536;

    localparam logic [1:0] RegFocalX = 2'd0;
    localparam logic [1:0] RegFocalY = 2'd1;
    localparam logic [1:0] RegCenterX = 2'd2;
    localparam logic [1:0] RegCenterY = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_CAM,
        ST_DIVX,
        ST_DIVY,
        ST_PIX,
        ST_SQRT,
        ST_ACC,
        ST_MEAN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/mre_div.sv =====
// shared unsigned restoring divider, one quotient bit per cycle
// depends on mre_pkg
`default_nettype none
module mre_div
    import mre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    div_state_t  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] trial;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        trial = {rem_reg[63:0], quo_reg[63]} - {1'b0, den_reg};
        case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    quo_next = req.num;
                    den_next = req.den;
                    rem_next = '0;
                    cnt_next = 7'd64;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (!trial[64])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[63:0], quo_reg[63]};
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = DIV_DONE;
            end
            DIV_DONE:
                state_next = DIV_IDLE;
            default:
                state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = (state_reg == DIV_DONE);
    assign rsp.quo = quo_reg;

endmodule
`default_nettype wire

// ===== src/mean_reprojection_error.sv =====
// mean reprojection error: top level with sequencer, shared multiplier,
// square root stepper and accumulator; uses mre_pkg and mre_div
//
// usage: the in channel carries pose words (kind 0) and keypoint words
// (kind 1) under valid/ready; the out channel carries one result word
// (mean_error, point_count) for each keypoint word with last set.
// configuration writes (cfg_we, cfg_index, cfg_data) land at once and
// belong between frames while nothing is in work.
// a pose word or an unusable keypoint needs no further work; a usable
// keypoint first runs the 33x32 multiplier (nine pose products) and one
// depth check, and a point with non-positive depth ends there.
// a counted point then runs two divisions on the serial divider (each
// with the focal product) and a square root. a last word adds the mean
// division (none with no counted point) before the result is offered.
// the serial divider sets the rate.
// ready is low while a word is in work and while the result waits; a
// stalled receiver holds the block with its result unchanged.
// reset clears the pose, sum, count and restores register defaults.
`default_nettype none
module mean_reprojection_error
    import mre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [3:0]  pose_index,
    input  wire logic signed [31:0] pose_value,
    input  wire logic signed [31:0] world_x,
    input  wire logic signed [31:0] world_y,
    input  wire logic signed [31:0] world_z,
    input  wire logic signed [31:0] observed_u,
    input  wire logic signed [31:0] observed_v,
    input  wire logic        usable,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] mean_error,
    output logic [CountW-1:0] point_count
);

    state_t state_reg, state_next;

    logic [30:0] focal_x_reg, focal_y_reg;
    logic signed [31:0] center_x_reg, center_y_reg;
    logic signed [31:0] pose_reg [12];
    logic [47:0] sum_reg;
    logic [CountW-1:0] cnt_reg;

    logic signed [31:0] wp_reg [3];
    logic signed [31:0] obs_u_reg, obs_v_reg;
    logic last_reg;
    logic [3:0] step_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] pc_reg [3];
    logic [63:0] sq_n_reg, sq_res_reg, sq_bit_reg;
    logic signed [31:0] mean_reg;
    logic [CountW-1:0] pc_out_reg;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [64:0] prod_reg;
    logic mul_valid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    mre_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic accept;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign mean_error = mean_reg;
    assign point_count = pc_out_reg;

    // step index: 0..8 products for camera coords
    logic [1:0] row, col;
    assign row = (step_reg < 4'd3) ? 2'd0 : (step_reg < 4'd6) ? 2'd1 : 2'd2;
    assign col = 2'(step_reg - 4'(row) * 4'd3);

    logic signed [31:0] pcz;
    logic [31:0] abs_pcz;
    logic [63:0] div_num_x;
    logic sign_x;
    logic signed [64:0] fnum_x;
    logic signed [65:0] quo_s, proj;
    logic signed [31:0] diff;
    logic [31:0] ad;
    logic [63:0] sq_sub;
    logic [48:0] sum_add;

    always_comb
    begin
        pcz = pc_reg[2];
        abs_pcz = pcz;
        fnum_x = prod_reg;
        sign_x = fnum_x[64];
        div_num_x = sign_x ? 64'(-fnum_x) : 64'(fnum_x);
    end

    // multiplier operand mux
    always_comb
    begin
        mul_a = {pose_reg[4'(row) * 4'd3 + 4'(col)][31], pose_reg[4'(row) * 4'd3 + 4'(col)]};
        mul_b = wp_reg[col];
        case (state_reg)
            ST_DIVX:
            begin
                mul_a = {2'b00, focal_x_reg};
                mul_b = pc_reg[0];
            end
            ST_DIVY:
            begin
                mul_a = {2'b00, focal_y_reg};
                mul_b = pc_reg[1];
            end
            default:
            begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic div_sign_reg;
    logic signed [31:0] proj_sat;
    logic signed [31:0] obs_sel;
    logic signed [31:0] cen_sel;

    always_comb
    begin
        quo_s = div_sign_reg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
        cen_sel = (state_reg == ST_DIVX) ? center_x_reg : center_y_reg;
        proj = quo_s + 66'(cen_sel);
        proj_sat = sat32(proj);
        obs_sel = (state_reg == ST_DIVX) ? obs_u_reg : obs_v_reg;
        diff = sat32(66'(obs_sel) - 66'(proj_sat));
        ad = diff[31] ? 32'(-diff) : 32'(diff);
        if (ad[31])
            ad = 32'h7FFF_FFFF;
        sq_sub = sq_res_reg + sq_bit_reg;
        sum_add = {1'b0, sum_reg} + 49'(sq_res_reg);
    end

    logic [63:0] du2_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (kind && usable && (32'(cnt_reg) < MaxPoints))
                        ? ST_MUL : (kind ? (last ? ST_MEAN : ST_IDLE) : ST_IDLE);
            ST_MUL:
                if (mul_valid_reg && step_reg == 4'd0)
                    state_next = ST_CAM;
            ST_CAM:
                state_next = (pcz > 32'sd0) ? ST_DIVX : (last_reg ? ST_MEAN : ST_IDLE);
            ST_DIVX:
                if (div_rsp.done)
                    state_next = ST_DIVY;
            ST_DIVY:
                if (div_rsp.done)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (sq_bit_reg == 64'd0)
                    state_next = ST_ACC;
            ST_ACC:
                state_next = last_reg ? ST_MEAN : ST_IDLE;
            ST_MEAN:
                if (cnt_reg == '0 || div_rsp.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    logic div_busy_reg;

    // divider requests
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num = div_num_x;
        div_req.den = {32'd0, abs_pcz};
        case (state_reg)
            ST_DIVX, ST_DIVY:
                div_req.start = mul_valid_reg && !div_busy_reg;
            ST_MEAN:
            begin
                div_req.start = (cnt_reg != '0) && !div_busy_reg;
                div_req.num = {16'd0, sum_reg};
                div_req.den = 64'(cnt_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            focal_x_reg <= 31'd32768000;
            focal_y_reg <= 31'd32768000;
            center_x_reg <= '0;
            center_y_reg <= '0;
            for (int i = 0; i < 12; i++)
                pose_reg[i] <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            step_reg <= '0;
            mul_valid_reg <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    RegFocalX: focal_x_reg <= cfg_data[30:0];
                    RegFocalY: focal_y_reg <= cfg_data[30:0];
                    RegCenterX: center_x_reg <= cfg_data;
                    RegCenterY: center_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && !kind && pose_index < 4'd12)
                pose_reg[pose_index] <= pose_value;
            if (div_req.start)
                div_busy_reg <= 1'b1;
            else if (div_rsp.done)
                div_busy_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    mul_valid_reg <= 1'b0;
                end
                ST_MUL:
                begin
                    mul_valid_reg <= 1'b1;
                    if (step_reg != 4'd8 || !mul_valid_reg)
                        step_reg <= (step_reg == 4'd8) ? 4'd8 : step_reg + 4'd1;
                    if (mul_valid_reg && step_reg == 4'd8)
                        step_reg <= 4'd0;
                end
                ST_CAM:
                    mul_valid_reg <= 1'b0;
                ST_DIVX, ST_DIVY:
                    mul_valid_reg <= !div_rsp.done;
                ST_ACC:
                begin
                    sum_reg <= sum_add[48] ? SumMax : sum_add[47:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_OUT:
                    if (out_ready)
                    begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    logic [3:0] pstep_reg;
    logic [1:0] prow;
    assign prow = (pstep_reg < 4'd3) ? 2'd0 : (pstep_reg < 4'd6) ? 2'd1 : 2'd2;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == ST_DIVX || state_reg == ST_DIVY)
            if (div_req.start)
                div_sign_reg <= sign_x ^ 1'b0;
        if (div_req.start && state_reg == ST_MEAN)
            div_sign_reg <= 1'b0;
        if (accept)
        begin
            wp_reg[0] <= world_x;
            wp_reg[1] <= world_y;
            wp_reg[2] <= world_z;
            obs_u_reg <= observed_u;
            obs_v_reg <= observed_v;
            last_reg <= last;
        end
        pstep_reg <= step_reg;
        if (state_reg == ST_MUL && mul_valid_reg)
        begin
            if (pstep_reg == 4'd0 || pstep_reg == 4'd3 || pstep_reg == 4'd6)
                acc_reg <= 66'(pose_reg[4'd9 + 4'(prow)]) + 66'(prod_reg >>> 16);
            else
                acc_reg <= acc_reg + 66'(prod_reg >>> 16);
            if (pstep_reg == 4'd2 || pstep_reg == 4'd5 || pstep_reg == 4'd8)
                pc_reg[prow] <= sat32(acc_reg + 66'(prod_reg >>> 16));
        end
        if (state_reg == ST_DIVX && div_rsp.done)
        begin
            du2_reg <= 64'(ad) * 64'(ad);
        end
        if (state_reg == ST_DIVY && div_rsp.done)
        begin
            sq_n_reg <= du2_reg + 64'(ad) * 64'(ad);
            sq_res_reg <= '0;
            sq_bit_reg <= 64'd1 << 62;
        end
        if (state_reg == ST_SQRT && sq_bit_reg != 64'd0)
        begin
            if (sq_n_reg >= sq_sub)
            begin
                sq_n_reg <= sq_n_reg - sq_sub;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (state_reg == ST_MEAN && state_next == ST_OUT)
        begin
            pc_out_reg <= cnt_reg;
            if (cnt_reg == '0)
                mean_reg <= NoneMean;
            else if (div_rsp.quo > 64'h7FFF_FFFF)
                mean_reg <= 32'sh7FFF_FFFF;
            else
                mean_reg <= div_rsp.quo[31:0];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_error))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MaxPoints)
        else $error("count beyond limit");

endmodule
`default_nettype wire
